// File: src/lggs_pkg.sv
// Package for the LED grayscale gamma serializer.
// Holds sizes, the queue entry type and the gamma ROM; no dependencies.
package lggs_pkg;

   localparam int GRAY_BITS   = 12;
   localparam int TABLE_DEPTH = 128;
   localparam int ROM_SIZE    = 128;
   localparam int CODE_W      = 12;
   localparam int LEVEL_W     = 8;
   localparam int ROM_IDX_W   = $clog2(ROM_SIZE);
   localparam int CLIP_IDX    = (TABLE_DEPTH - 1 > ROM_SIZE - 1) ? ROM_SIZE - 1
                                                                  : TABLE_DEPTH - 1;
   localparam int CNT_W       = $clog2(GRAY_BITS + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [0:0] MODE_TABLE = 1'b0;
   localparam logic [0:0] MODE_CURVE = 1'b1;

   typedef struct packed {
      logic [GRAY_BITS-1:0] code;
      logic                 frame_end;
   } item_type;

   localparam logic [CODE_W-1:0] GAMMA_ROM [ROM_SIZE] = '{
      12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1, 12'd1,
      12'd1, 12'd1, 12'd1, 12'd2, 12'd2, 12'd2, 12'd2, 12'd2,
      12'd2, 12'd3, 12'd3, 12'd3, 12'd3, 12'd3, 12'd4, 12'd4,
      12'd4, 12'd5, 12'd5, 12'd5, 12'd6, 12'd6, 12'd7, 12'd7,
      12'd7, 12'd8, 12'd9, 12'd9, 12'd10, 12'd11, 12'd11, 12'd12,
      12'd13, 12'd14, 12'd15, 12'd16, 12'd17, 12'd18, 12'd19, 12'd21,
      12'd22, 12'd24, 12'd25, 12'd27, 12'd29, 12'd31, 12'd33, 12'd35,
      12'd38, 12'd40, 12'd43, 12'd46, 12'd49, 12'd52, 12'd56, 12'd59,
      12'd63, 12'd68, 12'd72, 12'd77, 12'd82, 12'd88, 12'd94, 12'd100,
      12'd107, 12'd114, 12'd122, 12'd130, 12'd139, 12'd148, 12'd158, 12'd169,
      12'd181, 12'd193, 12'd206, 12'd219, 12'd234, 12'd250, 12'd267, 12'd285,
      12'd304, 12'd324, 12'd346, 12'd369, 12'd394, 12'd421, 12'd449, 12'd479,
      12'd511, 12'd546, 12'd583, 12'd622, 12'd663, 12'd708, 12'd756, 12'd806,
      12'd861, 12'd918, 12'd980, 12'd1046, 12'd1116, 12'd1191, 12'd1271, 12'd1357,
      12'd1448, 12'd1545, 12'd1649, 12'd1759, 12'd1878, 12'd2004, 12'd2138, 12'd2282,
      12'd2435, 12'd2599, 12'd2773, 12'd2959, 12'd3158, 12'd3370, 12'd3596, 12'd3838
   };

endpackage

// File: src/led_grayscale_gamma_serializer.sv
// Top level of the LED grayscale gamma serializer.
// Depends on lggs_pkg, lggs_front, lggs_queue and lggs_back.
//
//   channel   ports                                          handshake
//   request   req_level, req_frame_end                       req_push / req_full
//   response  rsp_data_bit, rsp_latch_pulse, rsp_last_of_run rsp_pop / rsp_empty
//   csr       csr_data (curve_select)                        csr_write
//
// Each pixel yields twelve response transactions, one per clock when not stalled,
// plus one latch transaction at a frame end; the serial output register sets this rate.
// A request is mapped in the cycle it is taken and waits in a two-entry queue.
// Reset is synchronous and active high; it empties the queue and selects table mode.
// A stalled response side fills the queue, after which req_full is raised.
module led_grayscale_gamma_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [lggs_pkg::LEVEL_W-1:0]  req_level,
   input  logic                          req_frame_end,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output logic                          rsp_data_bit,
   output logic                          rsp_latch_pulse,
   output logic                          rsp_last_of_run,
   input  logic                          csr_write,
   input  logic                          csr_data
);

   lggs_pkg::item_type front_item;
   lggs_pkg::item_type q_head;
   logic               q_empty;
   logic               q_pop;

   lggs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .level     (req_level),
      .frame_end (req_frame_end),
      .item      (front_item)
   );

   lggs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   lggs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_data_bit    (rsp_data_bit),
      .rsp_latch_pulse (rsp_latch_pulse),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: src/lggs_front.sv
// Front end of the LED grayscale gamma serializer: mode register and code mapping.
// Depends on lggs_pkg.
module lggs_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic                              csr_data,
   input  logic [lggs_pkg::LEVEL_W-1:0]      level,
   input  logic                              frame_end,
   output lggs_pkg::item_type                item
);

   logic mode_ff;
   logic mode_in;

   function automatic logic [lggs_pkg::CODE_W-1:0] curve_code(
      input logic [lggs_pkg::LEVEL_W-1:0] x
   );
      logic [13:0] y;
      logic [13:0] v;
      logic [17:0] prod;
      logic [13:0] r;
      begin
         y = {2'b00, x, 4'b0000};
         v = 14'd0;
         prod = 18'd0;
         r = 14'd0;
         if (x < 8'd10) begin
            r = 14'd0;
         end else if (x < 8'd20) begin
            r = 14'd16;
         end else if (x < 8'd50) begin
            v = y - 14'd320;
            prod = {4'b0000, v} * 18'd205;
            r = 14'(prod >> 10) + 14'd32;
         end else if (x < 8'd82) begin
            v = y - 14'd800;
            r = (v >> 2) + 14'd128;
         end else if (x < 8'd94) begin
            v = y - 14'd1312;
            prod = {4'b0000, v} * 18'd171;
            r = 14'(prod >> 9) + 14'd256;
         end else if (x < 8'd174) begin
            v = y - 14'd1504;
            r = (v >> 1) + 14'd320;
         end else if (x < 8'd199) begin
            r = y - 14'd2784 + 14'd960;
         end else if (x < 8'd239) begin
            r = ((y - 14'd3184) << 1) + 14'd1360;
         end else if (x < 8'd243) begin
            r = (y - 14'd3824) * 14'd3 + 14'd2640;
         end else if (x < 8'd250) begin
            r = (y - 14'd3888) * 14'd5 + 14'd2832;
         end else if (x < 8'd255) begin
            r = ((y - 14'd4000) << 3) + 14'd3392;
         end else begin
            r = 14'd4095;
         end
         return r[lggs_pkg::CODE_W-1:0];
      end
   endfunction

   logic [lggs_pkg::ROM_IDX_W-1:0] rom_idx;
   logic [lggs_pkg::CODE_W-1:0]    code;

   always_comb begin
      mode_in = mode_ff;
      if (csr_write) begin
         mode_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lggs_pkg::MODE_TABLE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      if (level > lggs_pkg::LEVEL_W'(lggs_pkg::CLIP_IDX)) begin
         rom_idx = lggs_pkg::ROM_IDX_W'(lggs_pkg::CLIP_IDX);
      end else begin
         rom_idx = level[lggs_pkg::ROM_IDX_W-1:0];
      end
      if (mode_ff == lggs_pkg::MODE_CURVE) begin
         code = curve_code(level);
      end else begin
         code = lggs_pkg::GAMMA_ROM[rom_idx];
      end
      item.code      = lggs_pkg::GRAY_BITS'(code);
      item.frame_end = frame_end;
   end

endmodule

// File: src/lggs_queue.sv
// Two-entry queue of mapped codes between front and back of the serializer.
// Depends on lggs_pkg.
module lggs_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lggs_pkg::item_type  push_item,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output lggs_pkg::item_type  head
);

   lggs_pkg::item_type               entry_ff [lggs_pkg::QUEUE_DEPTH];
   logic [lggs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [lggs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [lggs_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                             do_push, do_pop;

   assign full    = (count_ff == lggs_pkg::QCNT_W'(lggs_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == lggs_pkg::QPTR_W'(lggs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == lggs_pkg::QPTR_W'(lggs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/lggs_back.sv
// Back end of the serializer: shifts codes out MSB first and appends latch results.
// Depends on lggs_pkg; feeds an output register read by the result channel.
module lggs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  lggs_pkg::item_type  q_head,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output logic                rsp_data_bit,
   output logic                rsp_latch_pulse,
   output logic                rsp_last_of_run
);

   logic [lggs_pkg::GRAY_BITS-1:0] shift_ff, shift_in;
   logic [lggs_pkg::CNT_W-1:0]     bits_left_ff, bits_left_in;
   logic                           latch_ff, latch_in;
   logic                           out_valid_ff, out_valid_in;
   logic                           out_data_ff, out_data_in;
   logic                           out_latch_ff, out_latch_in;
   logic                           out_last_ff, out_last_in;
   logic                           busy, out_free, advance, final_result, take;

   assign busy         = (bits_left_ff != '0) || latch_ff;
   assign out_free     = !out_valid_ff || rsp_pop;
   assign advance      = busy && out_free;
   assign final_result = ((bits_left_ff == lggs_pkg::CNT_W'(1)) && !latch_ff) ||
                         ((bits_left_ff == '0) && latch_ff);
   assign take         = !q_empty && (!busy || (advance && final_result));
   assign q_pop        = take;

   always_comb begin
      shift_in     = shift_ff;
      bits_left_in = bits_left_ff;
      latch_in     = latch_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_data_in  = out_data_ff;
      out_latch_in = out_latch_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         if (bits_left_ff != '0) begin
            out_data_in  = shift_ff[lggs_pkg::GRAY_BITS-1];
            out_latch_in = 1'b0;
            out_last_in  = final_result;
            shift_in     = shift_ff << 1;
            bits_left_in = bits_left_ff - 1'b1;
         end else begin
            out_data_in  = 1'b0;
            out_latch_in = 1'b1;
            out_last_in  = 1'b1;
            latch_in     = 1'b0;
         end
      end
      if (take) begin
         shift_in     = q_head.code;
         bits_left_in = lggs_pkg::CNT_W'(lggs_pkg::GRAY_BITS);
         latch_in     = q_head.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= '0;
         latch_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         bits_left_ff <= bits_left_in;
         latch_ff     <= latch_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff     <= shift_in;
      out_data_ff  <= out_data_in;
      out_latch_ff <= out_latch_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_data_bit    = out_data_ff;
   assign rsp_latch_pulse = out_latch_ff;
   assign rsp_last_of_run = out_last_ff;

   a_latch_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_latch_ff) |-> (out_last_ff && !out_data_ff))
      else $error("latch result must carry last_of_run and a zero data bit");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= lggs_pkg::CNT_W'(lggs_pkg::GRAY_BITS))
      else $error("bit counter out of range");

   a_take_when_done: assert property (@(posedge clock) disable iff (reset)
      take |-> (!busy || final_result))
      else $error("new code loaded while the current one is unfinished");

   a_load_full: assert property (@(posedge clock) disable iff (reset)
      take |=> (bits_left_ff == lggs_pkg::CNT_W'(lggs_pkg::GRAY_BITS)))
      else $error("bit counter not reloaded after taking a code");

endmodule
